// ----- rtl/vna_pkg.sv -----
// Shared constants and item types for the vertex normal accumulator.
package vna_pkg;

  localparam int VERTEX_COUNT = 16384;
  localparam int ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int INDEX_W      = 14;
  localparam int POS_W        = 48;
  localparam int COMP_W       = 16;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] index_a;
    logic [POS_W-1:0]   pos_a;
    logic [INDEX_W-1:0] index_b;
    logic [POS_W-1:0]   pos_b;
    logic [INDEX_W-1:0] index_c;
    logic [POS_W-1:0]   pos_c;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]       vertex_index;
    logic signed [COMP_W-1:0] normal_x;
    logic signed [COMP_W-1:0] normal_y;
    logic signed [COMP_W-1:0] normal_z;
    logic                     saturated;
  } out_item_t;

endpackage

// ----- rtl/vertex_normal_accumulator_core.sv -----
// Vertex normal accumulator: normal store, triangle normal unit and read path.
// After reset the block clears its store, one entry a cycle, with busy high.
// A read item is accepted, the store is read and the output registered, and
// its result is strobed on out_strobe in the cycle in which busy drops. An add
// item is accepted, then goes through the cross product, the magnitudes, 0 to
// 29 one-bit normalization shifts plus a step that finds the range, the squares
// on one shared 31x31 multiplier, 32 square root steps, 3 divisions on a
// restoring divider, and a read-modify-write of the store for each corner. A
// triangle with a zero cross product ends after the magnitudes. Results cannot
// be held off by the receiver.
module vertex_normal_accumulator_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vna_pkg::in_item_t    in_item,
  output logic                 out_strobe,
  output vna_pkg::out_item_t   out_item
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDM  = 4'd2;
  localparam logic [3:0] S_RDO  = 4'd3;
  localparam logic [3:0] S_XP   = 4'd4;
  localparam logic [3:0] S_ABS  = 4'd5;
  localparam logic [3:0] S_NRM  = 4'd6;
  localparam logic [3:0] S_SQ   = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_DVS  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_UPR  = 4'd11;
  localparam logic [3:0] S_UPW  = 4'd12;

  localparam int AW = vna_pkg::ADDR_W;

  logic [3:0]          state_r;
  logic [AW-1:0]       clr_r;
  vna_pkg::in_item_t   item_r;
  logic [3:0]          cnt_r;
  logic [1:0]          kc_r;
  logic signed [61:0]  prod_r;
  logic signed [34:0]  cr_r [3];
  logic [33:0]         mag_r [3];
  logic [2:0]          neg_r;
  logic [61:0]         sum_r;
  logic [62:0]         res_r;
  logic [62:0]         bit_r;
  logic [40:0]         rem_r;
  logic [40:0]         dv_r;
  logic [10:0]         q_r;
  logic [10:0]         qk_r [3];
  logic [48:0]         rd_r;
  logic [48:0]         mem [vna_pkg::VERTEX_COUNT];

  logic signed [16:0]  e1 [3];
  logic signed [16:0]  e2 [3];
  logic signed [30:0]  mul_a;
  logic signed [30:0]  mul_b;
  logic [13:0]         corner;
  logic [13:0]         mem_ra;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [48:0]         mem_wd;
  logic [63:0]         sq_t;
  logic                sq_ge;
  logic [30:0]         len;
  logic [1:0]          xi;
  logic                hi_any;
  logic                b29_any;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = {item_r.pos_c[16*k+15], item_r.pos_c[16*k +: 16]}
            - {item_r.pos_a[16*k+15], item_r.pos_a[16*k +: 16]};
      e2[k] = {item_r.pos_c[16*k+15], item_r.pos_c[16*k +: 16]}
            - {item_r.pos_b[16*k+15], item_r.pos_b[16*k +: 16]};
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_XP) begin
      case (cnt_r)
        4'd0: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[2]); end
        4'd1: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[1]); end
        4'd2: begin mul_a = 31'(e1[2]); mul_b = 31'(e2[0]); end
        4'd3: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[2]); end
        4'd4: begin mul_a = 31'(e1[0]); mul_b = 31'(e2[1]); end
        4'd5: begin mul_a = 31'(e1[1]); mul_b = 31'(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == S_SQ && cnt_r < 4'd3) begin
      mul_a = {1'b0, mag_r[cnt_r[1:0]][29:0]};
      mul_b = {1'b0, mag_r[cnt_r[1:0]][29:0]};
    end
  end

  always_comb begin
    case (kc_r)
      2'd0:    corner = item_r.index_c;
      2'd1:    corner = item_r.index_a;
      default: corner = item_r.index_b;
    endcase
    mem_ra  = (state_r == S_UPR) ? corner : item_r.index_a;
    sq_t    = {1'b0, res_r} + {1'b0, bit_r};
    sq_ge   = {2'b00, sum_r} >= sq_t;
    len     = res_r[30:0];
    xi      = 2'((cnt_r - 4'd1) >> 1);
    hi_any  = |{mag_r[0][33:30], mag_r[1][33:30], mag_r[2][33:30]};
    b29_any = mag_r[0][29] | mag_r[1][29] | mag_r[2][29];
  end

  // store writes: clearing after reset and the update for the current corner
  always_comb begin
    logic signed [16:0] s;
    logic signed [11:0] d;
    logic               sat;
    s      = '0;
    d      = '0;
    mem_we = 1'b0;
    mem_wa = clr_r;
    mem_wd = '0;
    sat    = rd_r[48];
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
    end else if (state_r == S_UPW) begin
      mem_we = 1'b1;
      mem_wa = corner[AW-1:0];
      for (int k = 0; k < 3; k++) begin
        d = neg_r[k] ? -$signed({1'b0, qk_r[k]}) : $signed({1'b0, qk_r[k]});
        s = {rd_r[16*k+15], rd_r[16*k +: 16]} + 17'(d);
        if (s[16] != s[15]) begin
          sat = 1'b1;
          mem_wd[16*k +: 16] = s[16] ? 16'h8000 : 16'h7fff;
        end else begin
          mem_wd[16*k +: 16] = s[15:0];
        end
      end
      mem_wd[48] = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (start && !busy) begin
      item_r <= in_item;
    end
    case (state_r)
      S_IDLE: begin
        for (int k = 0; k < 3; k++) cr_r[k] <= '0;
      end
      S_XP: begin
        if (cnt_r != 4'd0) begin
          if (cnt_r[0]) cr_r[xi] <= cr_r[xi] + prod_r[34:0];
          else          cr_r[xi] <= cr_r[xi] - prod_r[34:0];
        end
      end
      S_ABS: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= cr_r[k][34];
          mag_r[k] <= cr_r[k][34] ? 34'(-cr_r[k]) : cr_r[k][33:0];
        end
        sum_r <= '0;
      end
      S_NRM: begin
        for (int k = 0; k < 3; k++) begin
          if (hi_any)        mag_r[k] <= mag_r[k] >> 1;
          else if (!b29_any) mag_r[k] <= mag_r[k] << 1;
        end
      end
      S_SQ: begin
        if (cnt_r != 4'd0) sum_r <= sum_r + prod_r[61:0];
        res_r <= '0;
        bit_r <= 63'(1) << 62;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sum_r <= sum_r - sq_t[61:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DVS: begin
        rem_r <= {1'b0, mag_r[kc_r][29:0], 10'b0} + 41'(len >> 1);
        dv_r  <= {len, 10'b0};
        q_r   <= '0;
      end
      S_DIV: begin
        if (rem_r >= dv_r) rem_r <= rem_r - dv_r;
        q_r  <= {q_r[9:0], rem_r >= dv_r};
        dv_r <= dv_r >> 1;
        if (cnt_r == 4'd11) qk_r[kc_r] <= q_r;
      end
      default: begin
      end
    endcase
    if (state_r == S_RDO) begin
      out_item.vertex_index <= item_r.index_a;
      if (32'(item_r.index_a) < vna_pkg::VERTEX_COUNT) begin
        out_item.normal_x  <= rd_r[15:0];
        out_item.normal_y  <= rd_r[31:16];
        out_item.normal_z  <= rd_r[47:32];
        out_item.saturated <= rd_r[48];
      end else begin
        out_item.normal_x  <= '0;
        out_item.normal_y  <= '0;
        out_item.normal_z  <= '0;
        out_item.saturated <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      cnt_r      <= '0;
      kc_r       <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == S_RDO);
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(vna_pkg::VERTEX_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          cnt_r <= '0;
          kc_r  <= '0;
          if (start) state_r <= in_item.action ? S_RDM : S_XP;
        end
        S_RDM: state_r <= S_RDO;
        S_RDO: state_r <= S_IDLE;
        S_XP: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd6) state_r <= S_ABS;
        end
        S_ABS: begin
          cnt_r   <= '0;
          state_r <= (cr_r[0] == '0 && cr_r[1] == '0 && cr_r[2] == '0) ? S_IDLE : S_NRM;
        end
        S_NRM: begin
          if (!hi_any && b29_any) state_r <= S_SQ;
        end
        S_SQ: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd3) state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (bit_r == 63'(1)) state_r <= S_DVS;
        end
        S_DVS: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd11) begin
            if (kc_r == 2'd2) begin
              kc_r    <= '0;
              state_r <= S_UPR;
            end else begin
              kc_r    <= kc_r + 2'd1;
              state_r <= S_DVS;
            end
          end
        end
        S_UPR: begin
          if (32'(corner) < vna_pkg::VERTEX_COUNT) begin
            state_r <= S_UPW;
          end else if (kc_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            kc_r <= kc_r + 2'd1;
          end
        end
        S_UPW: begin
          kc_r    <= kc_r + 2'd1;
          state_r <= (kc_r == 2'd2) ? S_IDLE : S_UPR;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for vertex_normal_accumulator_core: triangle adds and vertex reads.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam int   IDLE_LIMIT = 60000;
  localparam int   N_RANDOM   = 1250;

  class normal_scoreboard;
    int                 acc[vna_pkg::VERTEX_COUNT][3];
    bit                 sat_mark[vna_pkg::VERTEX_COUNT];
    vna_pkg::out_item_t pending_reads[$];
    int                 mismatches;

    function void add_to_vertex(int idx, int d[3]);
      int v;
      if (idx >= vna_pkg::VERTEX_COUNT) return;
      for (int k = 0; k < 3; k++) begin
        v = acc[idx][k] + d[k];
        if (v > 32767) begin
          v = 32767;
          sat_mark[idx] = 1'b1;
        end else if (v < -32768) begin
          v = -32768;
          sat_mark[idx] = 1'b1;
        end
        acc[idx][k] = v;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_input(vna_pkg::in_item_t it);
      longint a[3], b[3], c[3], e1[3], e2[3], cr[3];
      longint unsigned mag[3], m, sum, len, q;
      int d[3];
      vna_pkg::out_item_t r;
      if (it.action == ACT_READ) begin
        r.vertex_index = it.index_a;
        r.normal_x = 16'(acc[it.index_a][0]);
        r.normal_y = 16'(acc[it.index_a][1]);
        r.normal_z = 16'(acc[it.index_a][2]);
        r.saturated = sat_mark[it.index_a];
        pending_reads.push_back(r);
        return;
      end
      for (int k = 0; k < 3; k++) begin
        a[k] = longint'($signed(it.pos_a[16*k +: 16]));
        b[k] = longint'($signed(it.pos_b[16*k +: 16]));
        c[k] = longint'($signed(it.pos_c[16*k +: 16]));
        e1[k] = c[k] - a[k];
        e2[k] = c[k] - b[k];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
        if (mag[k] > m) m = mag[k];
      end
      if (m == 0) return;
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int k = 0; k < 3; k++) mag[k] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int k = 0; k < 3; k++) mag[k] <<= 1;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
      len = int_sqrt(sum);
      if (len == 0) return;
      for (int k = 0; k < 3; k++) begin
        q = (mag[k] * 1024 + (len >> 1)) / len;
        d[k] = cr[k] < 0 ? -int'(q) : int'(q);
      end
      add_to_vertex(int'(it.index_c), d);
      add_to_vertex(int'(it.index_a), d);
      add_to_vertex(int'(it.index_b), d);
    endfunction

    function void check(vna_pkg::out_item_t got);
      vna_pkg::out_item_t want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: vertex %0d n=(%0d,%0d,%0d) sat=%0b",
                   got.vertex_index, got.normal_x, got.normal_y, got.normal_z,
                   got.saturated);
        return;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp vertex %0d n=(%0d,%0d,%0d) sat=%0b, ",
                    "got vertex %0d n=(%0d,%0d,%0d) sat=%0b"},
                   want.vertex_index, want.normal_x, want.normal_y, want.normal_z,
                   want.saturated, got.vertex_index, got.normal_x, got.normal_y,
                   got.normal_z, got.saturated);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  vna_pkg::in_item_t  in_item;
  logic               out_strobe;
  vna_pkg::out_item_t out_item;

  normal_scoreboard sb;
  int idle_pct;
  int quiet_cycles = 0;

  vertex_normal_accumulator_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check(out_item);
    if (rst_n && ((start && !busy) || out_strobe)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[vertex_normal_accumulator_core] ERROR");
      $finish;
    end
  end

  function automatic logic [47:0] pack_pos(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [13:0] pick_index();
    if ($urandom_range(0, 99) < 80) return 14'($urandom_range(0, 31));
    return 14'($urandom_range(0, vna_pkg::VERTEX_COUNT - 1));
  endfunction

  function automatic logic [47:0] pick_pos();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 70)
      return pack_pos($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                      $urandom_range(0, 4095) - 2048);
    return 48'({$urandom, $urandom});
  endfunction

  function automatic vna_pkg::in_item_t random_item();
    vna_pkg::in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(vna_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 99) < 40) begin
      it.action = ACT_READ;
      it.index_a = pick_index();
      return it;
    end
    it.action = ACT_ADD;
    it.index_a = pick_index();
    it.index_b = pick_index();
    it.index_c = pick_index();
    it.pos_a = pick_pos();
    it.pos_b = pick_pos();
    it.pos_c = pick_pos();
    case ($urandom_range(0, 19))
      0: it.pos_b = it.pos_a;
      1: it.pos_c = it.pos_a;
      2: it.pos_c = it.pos_b;
      default: ;
    endcase
    return it;
  endfunction

  function automatic vna_pkg::in_item_t make_add(logic [13:0] ia, logic [47:0] pa,
                                                 logic [13:0] ib, logic [47:0] pb,
                                                 logic [13:0] ic, logic [47:0] pc);
    vna_pkg::in_item_t it;
    it.action = ACT_ADD;
    it.index_a = ia; it.pos_a = pa;
    it.index_b = ib; it.pos_b = pb;
    it.index_c = ic; it.pos_c = pc;
    return it;
  endfunction

  function automatic vna_pkg::in_item_t make_read(logic [13:0] idx);
    vna_pkg::in_item_t it;
    it = '0;
    it.action = ACT_READ;
    it.index_a = idx;
    return it;
  endfunction

  task automatic send(vna_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (idle_pct > 0)
      while ($urandom_range(0, 99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  initial begin
    logic [47:0] lo, hi;
    sb = new();
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    lo = pack_pos(-32768, -32768, -32768);
    hi = pack_pos(32767, 32767, 32767);
    send(make_read(14'd0));
    send(make_read(14'd16383));
    send(make_add(14'd1, pack_pos(0, 0, 0), 14'd2, pack_pos(256, 0, 0),
                  14'd3, pack_pos(0, 256, 0)));
    send(make_add(14'd16383, lo, 14'd0, pack_pos(32767, -32768, 0),
                  14'd8191, pack_pos(-32768, 32767, 32767)));
    send(make_add(14'd4, lo, 14'd5, hi, 14'd6, pack_pos(0, 0, 0)));
    send(make_add(14'd4, pack_pos(1, 0, 0), 14'd5, pack_pos(0, 1, 0),
                  14'd6, pack_pos(0, 0, 1)));
    send(make_add(14'd7, hi, 14'd7, lo, 14'd8, pack_pos(32767, -32768, 32767)));
    send(make_add(14'd9, hi, 14'd9, hi, 14'd9, hi));
    send(make_add(14'd10, pack_pos(5, 5, 5), 14'd10, pack_pos(-3, 7, 1),
                  14'd10, pack_pos(100, -200, 50)));
    for (int i = 0; i < 20; i++)
      send(make_add(14'd11, pack_pos(0, 0, 0), 14'd11, pack_pos(0, 256, 0),
                    14'd12, pack_pos(256, 0, 0)));
    foreach (sb.acc[i]) if (i < 13 || i > 16380) send(make_read(14'(i)));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 48 : (ph == 3) ? 34 : 0;
      for (int i = 0; i < N_RANDOM / 4; i++) send(random_item());
    end
    for (int i = 0; i < 32; i++) send(make_read(14'(i)));
    start <= 1'b0;

    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_reads.size() == 0) begin
      $display("[vertex_normal_accumulator_core] OK");
    end else begin
      $display("[vertex_normal_accumulator_core] ERROR");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/vna_pkg.sv
rtl/vertex_normal_accumulator_core.sv
bench/tb.sv
